// ----- rtl/core/rgba8_half_rate_fir_line_assert.svh -----
// Assertion macros shared by the modules of the half-rate line filter.
// Every property is clocked on the rising edge and is off while reset is low.
`ifndef RGBA8_HALF_RATE_FIR_LINE_ASSERT_SVH
`define RGBA8_HALF_RATE_FIR_LINE_ASSERT_SVH

// The condition holds on every clock edge.
`define RHFL_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequence holds on the same edge as the antecedent.
`define RHFL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequence holds on the edge after the antecedent.
`define RHFL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/rhfl_pkg.sv -----
`timescale 1ns / 1ps

package rhfl_pkg;

    localparam int MAX_SOURCE_LINE_DEF = 4096;
    localparam int COEF_FRAC_BITS_DEF  = 14;

    localparam int TAP_COUNT    = 12;
    localparam int CHANNELS     = 4;
    localparam int COEF_W       = 16;
    localparam int TAPS_PER_REG = 4;
    localparam int CFG_W        = 64;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_REGS     = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_TAPS_0_TO_3  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAPS_4_TO_7  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAPS_8_TO_11 = 2'd2;

    // An 8-bit unsigned byte times a signed 16-bit tap fits in 24 signed bits.
    localparam int PROD_W = 24;

    localparam int FIFO_DEPTH = 8;

    typedef logic [CHANNELS-1:0][7:0]        pixel_t;
    typedef logic [CHANNELS-1:0][PROD_W-1:0] prod_t;

    typedef struct packed {
        logic [7:0] ch0_in;
        logic [7:0] ch1_in;
        logic [7:0] ch2_in;
        logic [7:0] ch3_in;
        logic       last_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] ch0_out;
        logic [7:0] ch1_out;
        logic [7:0] ch2_out;
        logic [7:0] ch3_out;
        logic       last_out;
    } out_item_t;

    typedef struct packed {
        logic fill;
        logic shift;
    } win_ctl_t;

    typedef struct packed {
        logic valid;
        logic last;
    } beat_t;

    typedef enum logic {
        ST_RUN,
        ST_FLUSH
    } seq_state_t;

endpackage

// ----- rtl/core/rhfl_cell.sv -----
`timescale 1ns / 1ps

module rhfl_cell (
    input  logic                          clk,
    input  rhfl_pkg::win_ctl_t            ctl,
    input  rhfl_pkg::pixel_t              fill_pix,
    input  rhfl_pkg::pixel_t              right_pix,
    input  logic [rhfl_pkg::COEF_W-1:0]   coef,
    output rhfl_pkg::pixel_t              pix,
    output rhfl_pkg::prod_t               prod
);

    rhfl_pkg::pixel_t pix_reg;
    rhfl_pkg::pixel_t pix_next;
    rhfl_pkg::prod_t  prod_reg;
    rhfl_pkg::prod_t  prod_next;

    always_comb
    begin
        pix_next = pix_reg;
        if (ctl.fill)
        begin
            pix_next = fill_pix;
        end
        else if (ctl.shift)
        begin
            pix_next = right_pix;
        end
    end

    always_comb
    begin
        logic signed [rhfl_pkg::COEF_W+8:0] full;
        for (int c = 0; c < rhfl_pkg::CHANNELS; c++)
        begin
            full = $signed(coef) * $signed({1'b0, pix_reg[c]});
            prod_next[c] = full[rhfl_pkg::PROD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg  <= pix_next;
        prod_reg <= prod_next;
    end

    assign pix  = pix_reg;
    assign prod = prod_reg;

endmodule

// ----- rtl/core/rhfl_sum.sv -----
`timescale 1ns / 1ps

module rhfl_sum #(
    parameter int COEF_FRAC_BITS = rhfl_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rhfl_pkg::beat_t     beat,
    input  rhfl_pkg::prod_t     prod [rhfl_pkg::TAP_COUNT],
    output logic                push,
    output rhfl_pkg::out_item_t item
);

    localparam int GROUPS     = 4;
    localparam int GROUP_SIZE = rhfl_pkg::TAP_COUNT / GROUPS;
    localparam int PART_W     = rhfl_pkg::PROD_W + 2;
    localparam int SUM_W      = PART_W + 2;
    localparam int CH         = rhfl_pkg::CHANNELS;
    localparam logic signed [SUM_W:0] RND     = (SUM_W+1)'(2 ** (COEF_FRAC_BITS - 1));
    localparam logic signed [SUM_W:0] MAX_VAL = (SUM_W+1)'(255);

    logic signed [PART_W-1:0] part_reg [GROUPS][CH];
    logic signed [PART_W-1:0] part_next [GROUPS][CH];
    logic signed [SUM_W-1:0]  sum_reg [CH];
    logic signed [SUM_W-1:0]  sum_next [CH];
    rhfl_pkg::beat_t          beat_a_reg;
    rhfl_pkg::beat_t          beat_b_reg;
    logic [7:0]               byte_val [CH];

    function automatic logic [7:0] sat_round(input logic signed [SUM_W-1:0] acc);
        logic signed [SUM_W:0] t;
        logic signed [SUM_W:0] q;
        logic [7:0]            r;
        t = (SUM_W+1)'(acc) + RND;
        q = t >>> COEF_FRAC_BITS;
        if (t[SUM_W])
        begin
            r = 8'h00;
        end
        else if (q > MAX_VAL)
        begin
            r = 8'hFF;
        end
        else
        begin
            r = q[7:0];
        end
        return r;
    endfunction

    // First level: each group adds three neighboring taps.
    always_comb
    begin
        logic signed [PART_W-1:0] acc;
        for (int g = 0; g < GROUPS; g++)
        begin
            for (int c = 0; c < CH; c++)
            begin
                acc = '0;
                for (int j = 0; j < GROUP_SIZE; j++)
                begin
                    acc = acc + PART_W'($signed(prod[g * GROUP_SIZE + j][c]));
                end
                part_next[g][c] = acc;
            end
        end
    end

    always_comb
    begin
        logic signed [SUM_W-1:0] acc;
        for (int c = 0; c < CH; c++)
        begin
            acc = '0;
            for (int g = 0; g < GROUPS; g++)
            begin
                acc = acc + SUM_W'(part_reg[g][c]);
            end
            sum_next[c] = acc;
        end
    end

    always_ff @(posedge clk)
    begin
        part_reg <= part_next;
        sum_reg  <= sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_a_reg <= '0;
            beat_b_reg <= '0;
        end
        else
        begin
            beat_a_reg <= beat;
            beat_b_reg <= beat_a_reg;
        end
    end

    always_comb
    begin
        for (int c = 0; c < CH; c++)
        begin
            byte_val[c] = sat_round(sum_reg[c]);
        end
    end

    assign push          = beat_b_reg.valid;
    assign item.ch0_out  = byte_val[0];
    assign item.ch1_out  = byte_val[1];
    assign item.ch2_out  = byte_val[2];
    assign item.ch3_out  = byte_val[3];
    assign item.last_out = beat_b_reg.last;

endmodule

// ----- rtl/core/rhfl_fifo.sv -----
`timescale 1ns / 1ps
`include "rgba8_half_rate_fir_line_assert.svh"

module rhfl_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rhfl_pkg::out_item_t wr_item,
    output logic                res_valid,
    input  logic                res_ready,
    output rhfl_pkg::out_item_t res_data
);

    localparam int DEPTH = rhfl_pkg::FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    rhfl_pkg::out_item_t mem_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                pop;

    assign pop = res_valid && res_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    assign res_valid = (count_reg != '0);
    assign res_data  = mem_reg[rd_ptr_reg];

    `RHFL_ASSERT_IMPL(a_fifo_no_overflow, clk, rst_n, push, (count_reg != CNT_W'(DEPTH)) || pop, "result queue written while full")
    `RHFL_ASSERT_NEXT(a_fifo_count_up, clk, rst_n, push && !pop, count_reg == $past(count_reg) + CNT_W'(1), "result queue count did not follow a write")

endmodule

// ----- rtl/core/rgba8_half_rate_fir_line.sv -----
// Half-rate 12-tap horizontal filter for one line of RGBA8 pixels.
// Source pixels enter on the pix channel (valid/ready), one per transaction,
// with last_in on the final pixel of a line; filtered pixels leave on the res
// channel, one per output pixel, with last_out on the final one of the line.
// Taps are written through cfg_we/cfg_index/cfg_data; the user must do so only
// while the block is idle, which the block itself does not enforce. Source
// pixels are taken at one per cycle while pix_ready is high. Output i is the
// one started when source pixel 2i+6 is taken. After the last pixel of a line
// the window row shifts in the replicated last pixel, emitting the remaining
// one to three outputs; no pixel is taken then.
// Each result passes four register stages: tap products in the cells, two
// adder tree levels, then rounding into an 8-entry result queue.
// A stalled receiver leaves results in the queue; input continues until the
// queue plus the results still in the pipeline could no longer absorb a line
// end, then pix_ready drops. Reset clears the taps to zero, returns to the
// start of a line and empties the queue.
`timescale 1ns / 1ps
`include "rgba8_half_rate_fir_line_assert.svh"

module rgba8_half_rate_fir_line #(
    parameter int MAX_SOURCE_LINE = rhfl_pkg::MAX_SOURCE_LINE_DEF,
    parameter int COEF_FRAC_BITS  = rhfl_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rhfl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rhfl_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             pix_valid,
    output logic                             pix_ready,
    input  rhfl_pkg::in_item_t               pix_data,
    output logic                             res_valid,
    input  logic                             res_ready,
    output rhfl_pkg::out_item_t              res_data
);

    localparam int POS_W = (MAX_SOURCE_LINE > 2) ? $clog2(MAX_SOURCE_LINE) : 1;
    localparam int PW    = (POS_W < 3) ? 3 : POS_W;
    localparam int RES_W = $clog2(rhfl_pkg::FIFO_DEPTH + 1);
    localparam int TC    = rhfl_pkg::TAP_COUNT;

    logic [rhfl_pkg::CFG_W-1:0] coef_bank_reg [rhfl_pkg::CFG_REGS];
    logic [rhfl_pkg::COEF_W-1:0] coef [TC];

    rhfl_pkg::seq_state_t state_reg;
    rhfl_pkg::seq_state_t state_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [2:0]       shift_cnt_reg;
    logic [2:0]       shift_cnt_next;
    logic [2:0]       s0_reg;
    logic [2:0]       s0_next;
    logic             odd_reg;
    logic             odd_next;
    logic             iss_valid_reg;
    logic             iss_valid_next;
    logic             iss_last_reg;
    logic             iss_last_next;
    logic [RES_W-1:0] reserved_reg;
    logic [RES_W-1:0] reserved_next;
    rhfl_pkg::beat_t  prod_beat_reg;

    logic             accept;
    logic             line_end;
    logic [PW-1:0]    pos_w;
    logic [1:0]       n_line;
    logic [2:0]       s0_line;
    logic [2:0]       shift_cnt_inc;
    logic [2:0]       flush_end;
    rhfl_pkg::win_ctl_t win_ctl;
    rhfl_pkg::pixel_t   in_pix;
    rhfl_pkg::pixel_t   win [TC];
    rhfl_pkg::pixel_t   right_pix [TC];
    rhfl_pkg::prod_t    prod [TC];
    logic               sum_push;
    rhfl_pkg::out_item_t sum_item;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < rhfl_pkg::CFG_REGS; r++)
            begin
                coef_bank_reg[r] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rhfl_pkg::CFG_TAPS_0_TO_3:  coef_bank_reg[0] <= cfg_data;
                rhfl_pkg::CFG_TAPS_4_TO_7:  coef_bank_reg[1] <= cfg_data;
                rhfl_pkg::CFG_TAPS_8_TO_11: coef_bank_reg[2] <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign in_pix    = {pix_data.ch3_in, pix_data.ch2_in, pix_data.ch1_in, pix_data.ch0_in};
    assign pix_ready = (state_reg == rhfl_pkg::ST_RUN) &&
                       (reserved_reg <= RES_W'(rhfl_pkg::FIFO_DEPTH - 3));
    assign accept    = pix_valid && pix_ready;
    assign line_end  = pix_data.last_in || (pos_reg == POS_W'(MAX_SOURCE_LINE - 1));
    assign pos_w     = PW'(pos_reg);

    // Outputs still owed at a line end, and the window shift of the first one.
    always_comb
    begin
        if (pos_w >= PW'(5))
        begin
            n_line = 2'd3;
        end
        else if ((pos_w == PW'(3)) || (pos_w == PW'(4)))
        begin
            n_line = 2'd2;
        end
        else
        begin
            n_line = 2'd1;
        end
        s0_line = 3'(6 + int'(pos_reg[0]) - 2 * int'(n_line));
    end

    assign shift_cnt_inc = shift_cnt_reg + 3'd1;
    assign flush_end     = {2'b10, odd_reg};

    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            pos_next = line_end ? '0 : pos_reg + POS_W'(1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rhfl_pkg::ST_RUN:
            begin
                if (accept && line_end)
                begin
                    state_next = rhfl_pkg::ST_FLUSH;
                end
            end
            rhfl_pkg::ST_FLUSH:
            begin
                if (shift_cnt_inc == flush_end)
                begin
                    state_next = rhfl_pkg::ST_RUN;
                end
            end
            default:
            begin
                state_next = rhfl_pkg::ST_RUN;
            end
        endcase
    end

    always_comb
    begin
        iss_valid_next = 1'b0;
        iss_last_next  = 1'b0;
        shift_cnt_next = shift_cnt_reg;
        s0_next        = s0_reg;
        odd_next       = odd_reg;
        win_ctl        = '0;
        unique case (state_reg)
            rhfl_pkg::ST_RUN:
            begin
                if (accept)
                begin
                    win_ctl.fill  = (pos_reg == '0);
                    win_ctl.shift = (pos_reg != '0);
                    if (line_end)
                    begin
                        shift_cnt_next = '0;
                        s0_next        = s0_line;
                        odd_next       = pos_reg[0];
                        iss_valid_next = (s0_line == 3'd0);
                    end
                    else
                    begin
                        iss_valid_next = (pos_w >= PW'(6)) && !pos_reg[0];
                    end
                end
            end
            rhfl_pkg::ST_FLUSH:
            begin
                // The row moves one place per cycle with the last pixel held
                // at the right end; every second position yields an output.
                win_ctl.shift  = 1'b1;
                shift_cnt_next = shift_cnt_inc;
                iss_valid_next = (shift_cnt_inc >= s0_reg) && (shift_cnt_inc[0] == s0_reg[0]);
                iss_last_next  = (shift_cnt_inc == flush_end);
            end
            default:
            begin
            end
        endcase
    end

    assign reserved_next = reserved_reg + RES_W'(iss_valid_next) - RES_W'(res_valid && res_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rhfl_pkg::ST_RUN;
            pos_reg       <= '0;
            shift_cnt_reg <= '0;
            s0_reg        <= '0;
            odd_reg       <= 1'b0;
            iss_valid_reg <= 1'b0;
            iss_last_reg  <= 1'b0;
            reserved_reg  <= '0;
            prod_beat_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            shift_cnt_reg <= shift_cnt_next;
            s0_reg        <= s0_next;
            odd_reg       <= odd_next;
            iss_valid_reg <= iss_valid_next;
            iss_last_reg  <= iss_last_next;
            reserved_reg  <= reserved_next;
            prod_beat_reg <= '{valid: iss_valid_reg, last: iss_last_reg};
        end
    end

    generate
        for (genvar k = 0; k < TC; k++)
        begin : g_cell
            assign coef[k] = coef_bank_reg[k / rhfl_pkg::TAPS_PER_REG]
                                [rhfl_pkg::COEF_W * (k % rhfl_pkg::TAPS_PER_REG) +: rhfl_pkg::COEF_W];

            if (k == TC - 1)
            begin : g_edge
                assign right_pix[k] = (state_reg == rhfl_pkg::ST_FLUSH) ? win[k] : in_pix;
            end
            else
            begin : g_inner
                assign right_pix[k] = win[k + 1];
            end

            rhfl_cell u_cell (
                .clk       (clk),
                .ctl       (win_ctl),
                .fill_pix  (in_pix),
                .right_pix (right_pix[k]),
                .coef      (coef[k]),
                .pix       (win[k]),
                .prod      (prod[k])
            );
        end
    endgenerate

    rhfl_sum #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_sum (
        .clk   (clk),
        .rst_n (rst_n),
        .beat  (prod_beat_reg),
        .prod  (prod),
        .push  (sum_push),
        .item  (sum_item)
    );

    rhfl_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (sum_push),
        .wr_item   (sum_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    `RHFL_ASSERT_ALWAYS(a_reserved_bound, clk, rst_n, reserved_reg <= RES_W'(rhfl_pkg::FIFO_DEPTH), "more results owed than the queue holds")
    `RHFL_ASSERT_IMPL(a_no_take_in_flush, clk, rst_n, state_reg == rhfl_pkg::ST_FLUSH, !pix_ready, "pixel taken while the line end drains")
    `RHFL_ASSERT_NEXT(a_line_end_flush, clk, rst_n, accept && line_end, (state_reg == rhfl_pkg::ST_FLUSH) && (pos_reg == '0), "line end did not start the drain")

endmodule

// ----- tb/tb_rgba8_half_rate_fir_line.sv -----
`timescale 1ns / 1ps

module tb_rgba8_half_rate_fir_line;

    localparam int IDLE_PCT       = 37;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 300;
    localparam int STALL_CYCLES   = 400;

    typedef enum int {
        KERNEL_SINC,
        KERNEL_RANDOM,
        KERNEL_SMALL,
        KERNEL_HALF_PAIR
    } kernel_kind_t;

    logic                             clk;
    logic                             rst_n     = 1'b0;
    logic                             cfg_we    = 1'b0;
    logic [rhfl_pkg::CFG_INDEX_W-1:0] cfg_index = rhfl_pkg::CFG_TAPS_0_TO_3;
    logic [rhfl_pkg::CFG_W-1:0]       cfg_data  = '0;
    logic                             pix_valid = 1'b0;
    logic                             pix_ready;
    rhfl_pkg::in_item_t               pix_data  = '0;
    logic                             res_valid;
    logic                             res_ready = 1'b0;
    rhfl_pkg::out_item_t              res_data;

    // Shadow of the tap registers, the pixel window and the line position.
    logic [rhfl_pkg::CFG_W-1:0] tap_regs [rhfl_pkg::CFG_REGS];
    logic [31:0]                window_q [rhfl_pkg::TAP_COUNT];
    logic [12:0]                src_pos;
    rhfl_pkg::out_item_t        expected_pixels [$];

    logic [15:0]                      tap_set [rhfl_pkg::TAP_COUNT];
    logic [rhfl_pkg::CFG_INDEX_W-1:0] tap_reg_index [rhfl_pkg::CFG_REGS] =
        '{rhfl_pkg::CFG_TAPS_0_TO_3, rhfl_pkg::CFG_TAPS_4_TO_7, rhfl_pkg::CFG_TAPS_8_TO_11};
    int sinc_taps [rhfl_pkg::TAP_COUNT] =
        '{-120, -250, 300, 1100, 3300, 4500, 4200, 2400, 800, -100, -250, -90};

    bit calm          = 1'b0;
    int stall_request = 0;
    int hold_left     = 0;
    int mismatch_count = 0;
    int idle_cycles;

    rgba8_half_rate_fir_line u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix_data  (pix_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic signed [15:0] tap_weight(int k);
        return tap_regs[k / rhfl_pkg::TAPS_PER_REG]
                       [rhfl_pkg::COEF_W * (k % rhfl_pkg::TAPS_PER_REG) +: rhfl_pkg::COEF_W];
    endfunction

    function automatic logic [7:0] round_saturate(longint acc);
        longint t;
        t = acc + (longint'(1) << (rhfl_pkg::COEF_FRAC_BITS_DEF - 1));
        if (t < 0)
            return 8'd0;
        t = t >>> rhfl_pkg::COEF_FRAC_BITS_DEF;
        if (t > 255)
            return 8'hFF;
        return t[7:0];
    endfunction

    // Output i of the line while the window holds source pixels p-11 .. p.
    function automatic rhfl_pkg::out_item_t filter_output(int i, int p, bit last);
        longint              acc [rhfl_pkg::CHANNELS];
        int                  x;
        int                  idx;
        rhfl_pkg::out_item_t r;
        for (int c = 0; c < rhfl_pkg::CHANNELS; c++)
            acc[c] = 0;
        for (int k = 0; k < rhfl_pkg::TAP_COUNT; k++)
        begin
            x = 2 * i - 5 + k;
            if (x > p)
                x = p;
            idx = x - p + rhfl_pkg::TAP_COUNT - 1;
            if (idx < 0)
                idx = 0;
            if (idx > rhfl_pkg::TAP_COUNT - 1)
                idx = rhfl_pkg::TAP_COUNT - 1;
            for (int c = 0; c < rhfl_pkg::CHANNELS; c++)
                acc[c] += longint'(tap_weight(k)) * longint'(window_q[idx][8 * c +: 8]);
        end
        r.ch0_out  = round_saturate(acc[0]);
        r.ch1_out  = round_saturate(acc[1]);
        r.ch2_out  = round_saturate(acc[2]);
        r.ch3_out  = round_saturate(acc[3]);
        r.last_out = last;
        return r;
    endfunction

    function automatic void predict_pixel(rhfl_pkg::in_item_t item);
        logic [31:0] pix;
        int          p;
        bit          last;
        int          total;
        int          done;
        int          n;
        pix  = {item.ch3_in, item.ch2_in, item.ch1_in, item.ch0_in};
        p    = src_pos;
        last = item.last_in || (p >= rhfl_pkg::MAX_SOURCE_LINE_DEF - 1);
        if (p == 0)
        begin
            for (int k = 0; k < rhfl_pkg::TAP_COUNT; k++)
                window_q[k] = pix;
        end
        else
        begin
            for (int k = 0; k < rhfl_pkg::TAP_COUNT - 1; k++)
                window_q[k] = window_q[k + 1];
            window_q[rhfl_pkg::TAP_COUNT - 1] = pix;
        end
        if (last)
        begin
            // The line end flushes the outputs not yet emitted, at most three.
            total = (p + 1) / 2;
            done  = (p >= 7) ? (p - 5) / 2 : 0;
            if (total < 1)
                total = 1;
            n = 0;
            for (int i = done; i < total && n < 3; i++)
            begin
                expected_pixels.push_back(filter_output(i, p, i == total - 1));
                n++;
            end
            src_pos = '0;
        end
        else
        begin
            if (p >= 6 && (p % 2) == 0)
                expected_pixels.push_back(filter_output((p - 6) / 2, p, 1'b0));
            src_pos = src_pos + 1'b1;
        end
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic rhfl_pkg::in_item_t make_pixel(logic [7:0] b0, logic [7:0] b1,
                                                      logic [7:0] b2, logic [7:0] b3,
                                                      logic last);
        rhfl_pkg::in_item_t item;
        item.ch0_in  = b0;
        item.ch1_in  = b1;
        item.ch2_in  = b2;
        item.ch3_in  = b3;
        item.last_in = last;
        return item;
    endfunction

    task automatic send_pixel(input rhfl_pkg::in_item_t item);
        if (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < IDLE_PCT)
                @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= item;
        @(posedge clk);
        while (!pix_ready)
            @(posedge clk);
        predict_pixel(item);
    endtask

    task automatic send_line(input int len);
        for (int j = 0; j < len; j++)
            send_pixel(make_pixel(rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                                  j == len - 1));
    endtask

    // Let every expected pixel arrive, then let the flush and pipeline settle.
    task automatic wait_drained;
        pix_valid <= 1'b0;
        @(posedge clk);
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_taps;
        logic [rhfl_pkg::CFG_W-1:0] packed_taps;
        cfg_we <= 1'b1;
        for (int r = 0; r < rhfl_pkg::CFG_REGS; r++)
        begin
            packed_taps = {tap_set[4 * r + 3], tap_set[4 * r + 2],
                           tap_set[4 * r + 1], tap_set[4 * r]};
            cfg_index <= tap_reg_index[r];
            cfg_data  <= packed_taps;
            tap_regs[r] = packed_taps;
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic fill_taps(input logic [15:0] value);
        for (int k = 0; k < rhfl_pkg::TAP_COUNT; k++)
            tap_set[k] = value;
    endtask

    task automatic choose_taps;
        kernel_kind_t kind;
        int           t;
        kind = kernel_kind_t'($urandom_range(3));
        for (int k = 0; k < rhfl_pkg::TAP_COUNT; k++)
        begin
            case (kind)
                KERNEL_SINC:   t = sinc_taps[k] + int'($urandom_range(512)) - 256;
                KERNEL_RANDOM: t = int'($urandom_range(65535));
                KERNEL_SMALL:  t = int'($urandom_range(8192)) - 4096;
                default:       t = 0;
            endcase
            tap_set[k] = t[15:0];
        end
        if (kind == KERNEL_HALF_PAIR)
        begin
            tap_set[$urandom_range(rhfl_pkg::TAP_COUNT - 1)] = 16'h2000;
            tap_set[$urandom_range(rhfl_pkg::TAP_COUNT - 1)] = 16'h2000;
        end
        load_taps();
    endtask

    // Taps are still zero from reset, so every output is zero.
    task automatic test_reset_taps;
        send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
        send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b1));
        wait_drained();
    endtask

    // A single unit tap passes every even source pixel through, which exposes
    // short lines, odd lengths and the clamping at both ends.
    task automatic test_short_lines;
        fill_taps(16'h0000);
        tap_set[5] = 16'h4000;
        load_taps();
        send_line(1);
        send_line(2);
        send_line(6);
        send_line(7);
        wait_drained();
    endtask

    // Two half taps average a pixel pair; odd sums land exactly on one half.
    task automatic test_rounding;
        fill_taps(16'h0000);
        tap_set[5] = 16'h2000;
        tap_set[6] = 16'h2000;
        load_taps();
        send_pixel(make_pixel(8'h01, 8'hFE, 8'h00, 8'hFF, 1'b0));
        send_pixel(make_pixel(8'h02, 8'hFF, 8'h01, 8'h00, 1'b1));
        wait_drained();
    endtask

    task automatic test_saturation;
        fill_taps(16'h7FFF);
        load_taps();
        send_line(3);
        wait_drained();
        fill_taps(16'h8000);
        load_taps();
        send_line(2);
        wait_drained();
    endtask

    task automatic test_random_lines;
        int sent;
        int phase;
        int len;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            choose_taps();
            calm = (phase == 1);
            repeat ($urandom_range(3, 8))
            begin
                if (sent < RANDOM_ITEMS)
                begin
                    case ($urandom_range(9))
                        0:       len = $urandom_range(1, 6);
                        1:       len = $urandom_range(30, 80);
                        default: len = $urandom_range(7, 24);
                    endcase
                    send_line(len);
                    sent += len;
                end
            end
            wait_drained();
            phase++;
        end
        calm = 1'b0;
    endtask

    // The receiver holds off while a long line keeps coming, so the result
    // queue fills and the block has to stall its input.
    task automatic test_backpressure;
        for (int k = 0; k < rhfl_pkg::TAP_COUNT; k++)
            tap_set[k] = sinc_taps[k][15:0];
        load_taps();
        stall_request = STALL_CYCLES;
        send_line(80);
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        if (stall_request > 0)
        begin
            hold_left     = stall_request;
            stall_request = 0;
        end
        if (hold_left > 0)
        begin
            res_ready <= 1'b0;
            hold_left--;
        end
        else
            res_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected result ch %h %h %h %h last %b, none expected",
                         $time, res_data.ch0_out, res_data.ch1_out, res_data.ch2_out,
                         res_data.ch3_out, res_data.last_out);
                mismatch_count++;
            end
            else
            begin
                if (res_data.ch0_out  !== expected_pixels[0].ch0_out  ||
                    res_data.ch1_out  !== expected_pixels[0].ch1_out  ||
                    res_data.ch2_out  !== expected_pixels[0].ch2_out  ||
                    res_data.ch3_out  !== expected_pixels[0].ch3_out  ||
                    res_data.last_out !== expected_pixels[0].last_out)
                begin
                    $display("%0t: expected ch %h %h %h %h last %b, got ch %h %h %h %h last %b",
                             $time, expected_pixels[0].ch0_out, expected_pixels[0].ch1_out,
                             expected_pixels[0].ch2_out, expected_pixels[0].ch3_out,
                             expected_pixels[0].last_out, res_data.ch0_out, res_data.ch1_out,
                             res_data.ch2_out, res_data.ch3_out, res_data.last_out);
                    mismatch_count++;
                end
                void'(expected_pixels.pop_front());
            end
        end
    end

    // Ends the run when no transaction has happened on either channel for too long.
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((pix_valid && pix_ready) || (res_valid && res_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        for (int r = 0; r < rhfl_pkg::CFG_REGS; r++)
            tap_regs[r] = '0;
        for (int k = 0; k < rhfl_pkg::TAP_COUNT; k++)
            window_q[k] = '0;
        src_pos = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_taps();
        test_short_lines();
        test_rounding();
        test_saturation();
        test_random_lines();
        test_backpressure();

        if (mismatch_count == 0 && expected_pixels.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
